// ===== rtl/core/sobel_edge_magnitude_top_defines.svh =====
// assertion macros shared by the sobel edge magnitude rtl
`ifndef SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SEM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sobel edge magnitude check failed");

// consequent checked in the cycle after the antecedent
`define SEM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sobel edge magnitude check failed");

`endif

// ===== rtl/core/sem_pkg.sv =====
// shared constants and types for the sobel edge magnitude block
package sem_pkg;

    // payload widths
    localparam int PIX_W     = 8;
    localparam int ROW_W     = 12;
    localparam int COL_W     = 8;
    localparam int WIDTH_W   = 9;
    localparam int HEIGHT_W  = 13;

    // apb port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register indexes (paddr[2])
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // register reset values
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 9'd256;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd256;

    // frame limits
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 13'd4096;
    localparam int MAX_WIDTH_DEFAULT = 256;
    localparam int WIDTH_LIMIT       = 256;

    // magnitude
    localparam int ROOT_STEPS = 8;
    localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
    localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic win;
        logic grad;
        logic sq;
        logic sum;
        logic root_step;
        logic out_load;
    } sem_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic root_last;
        logic out_blocked;
    } sem_status_t;

endpackage

// ===== rtl/core/sem_cfg_regs.sv =====
// apb configuration registers for frame width and height
module sem_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sem_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sem_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sem_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [sem_pkg::WIDTH_W-1:0]     image_width,
    output logic [sem_pkg::HEIGHT_W-1:0]    image_height
);
    import sem_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                wr_en;
    logic                reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            if (reg_idx == REG_IMAGE_WIDTH)
            begin
                width_reg <= pwdata[WIDTH_W-1:0];
            end
            else
            begin
                height_reg <= pwdata[HEIGHT_W-1:0];
            end
        end
    end

    // read back
    always_comb
    begin
        if (reg_idx == REG_IMAGE_WIDTH)
        begin
            prdata = {{(APB_DATA_W-WIDTH_W){1'b0}}, width_reg};
        end
        else
        begin
            prdata = {{(APB_DATA_W-HEIGHT_W){1'b0}}, height_reg};
        end
    end

    assign image_width  = width_reg;
    assign image_height = height_reg;

endmodule

// ===== rtl/core/sem_ctrl.sv =====
// controller state machine sequencing one pixel through the datapath
`include "sobel_edge_magnitude_top_defines.svh"
module sem_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sem_pkg::sem_status_t status,
    output sem_pkg::sem_cmd_t    cmd
);
    import sem_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_WIN  = 7'b0000010,
        ST_GRAD = 7'b0000100,
        ST_SQ   = 7'b0001000,
        ST_SUM  = 7'b0010000,
        ST_ROOT = 7'b0100000,
        ST_OUT  = 7'b1000000
    } sem_state_t;

    sem_state_t state_reg;
    sem_state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_WIN;
                end
            end
            ST_WIN:
            begin
                cmd.win    = 1'b1;
                state_next = ST_GRAD;
            end
            ST_GRAD:
            begin
                cmd.grad   = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!status.out_blocked)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    `SEM_ASSERT_NEXT(a_accept_to_win, in_valid && !in_stall, state_reg == ST_WIN)
    `SEM_ASSERT_SAME(a_no_load_when_blocked, cmd.out_load, !status.out_blocked)

endmodule

// ===== rtl/core/sem_datapath.sv =====
// datapath: position counters, line store, window, gradient, root, output register
`include "sobel_edge_magnitude_top_defines.svh"
module sem_datapath #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sem_pkg::sem_cmd_t             cmd,
    output sem_pkg::sem_status_t          status,
    input  logic [sem_pkg::PIX_W-1:0]     pixel,
    input  logic [sem_pkg::WIDTH_W-1:0]   image_width,
    input  logic [sem_pkg::HEIGHT_W-1:0]  image_height,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sem_pkg::PIX_W-1:0]     edge_value,
    output logic [sem_pkg::ROW_W-1:0]     out_row,
    output logic [sem_pkg::COL_W-1:0]     out_col,
    output logic                          frame_end
);
    import sem_pkg::*;

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int WCAP   = (MAX_WIDTH < WIDTH_LIMIT) ? MAX_WIDTH : WIDTH_LIMIT;
    localparam int GSUM_W = PIX_W + 2;
    localparam int SQ_W   = 2 * GSUM_W;
    localparam int S_W    = SQ_W + 1;
    localparam int RAD_W  = 2 * ROOT_STEPS;
    localparam int REM_W  = PIX_W + 1;

    // position counters
    logic [ROW_W-1:0]     row_count_reg;
    logic [COL_W-1:0]     col_count_reg;

    // captured transaction
    logic [PIX_W-1:0]     pix_reg;
    logic [AW-1:0]        addr_reg;
    logic                 in_range_reg;
    logic [ROW_W-1:0]     orow_reg;
    logic [COL_W-1:0]     ocol_reg;
    logic                 fend_reg;
    logic                 interior_reg;

    // line store: upper byte row r-1, lower byte row r-2
    logic [2*PIX_W-1:0]   line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0]   rd_word_reg;
    logic [PIX_W-1:0]     win_reg [9];

    // gradient and root
    logic [GSUM_W-1:0]    gx_abs_reg;
    logic [GSUM_W-1:0]    gy_abs_reg;
    logic [SQ_W-1:0]      sqx_reg;
    logic [SQ_W-1:0]      sqy_reg;
    logic                 sat_reg;
    logic [RAD_W-1:0]     rad_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [PIX_W-1:0]     root_reg;
    logic [ROOT_CNT_W-1:0] step_cnt_reg;

    // output register
    logic                 out_valid_reg;
    logic [PIX_W-1:0]     edge_value_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [COL_W-1:0]     out_col_reg;
    logic                 frame_end_reg;

    // combinational helpers
    logic [WIDTH_W-1:0]   eff_w;
    logic [HEIGHT_W-1:0]  eff_h;
    logic [ROW_W-1:0]     orow;
    logic [COL_W-1:0]     ocol;
    logic                 interior;
    logic                 col_wrap;
    logic                 row_wrap;
    logic                 c_in_range;
    logic [PIX_W-1:0]     above1;
    logic [PIX_W-1:0]     above2;
    logic [GSUM_W-1:0]    gx_p, gx_n, gy_p, gy_n;
    logic [S_W-1:0]       s_sum;
    logic [REM_W+1:0]     rem_sh;
    logic [PIX_W-1:0]     root_sh;
    logic [REM_W+1:0]     trial;
    logic [PIX_W-1:0]     edge_sel;

    // effective frame size
    always_comb
    begin
        if (image_width == '0)
            eff_w = WIDTH_W'(1);
        else if (image_width > WIDTH_W'(WCAP))
            eff_w = WIDTH_W'(WCAP);
        else
            eff_w = image_width;

        if (image_height == '0)
            eff_h = HEIGHT_W'(1);
        else if (image_height > HEIGHT_MAX)
            eff_h = HEIGHT_MAX;
        else
            eff_h = image_height;
    end

    // output position, border test and wrap flags
    assign orow = (row_count_reg == '0) ? ROW_W'(eff_h - HEIGHT_W'(1))
                                        : row_count_reg - ROW_W'(1);
    assign ocol = (col_count_reg == '0) ? COL_W'(eff_w - WIDTH_W'(1))
                                        : col_count_reg - COL_W'(1);
    assign interior = (orow > ROW_W'(2)) && (({1'b0, orow} + HEIGHT_W'(3)) < eff_h)
                   && (ocol > COL_W'(2)) && (({1'b0, ocol} + WIDTH_W'(3)) < eff_w);
    assign col_wrap = ({1'b0, col_count_reg} + WIDTH_W'(1)) >= eff_w;
    assign row_wrap = ({1'b0, row_count_reg} + HEIGHT_W'(1)) >= eff_h;
    assign c_in_range = ({{(HEIGHT_W-COL_W){1'b0}}, col_count_reg} < HEIGHT_W'(MAX_WIDTH));

    // counters and transaction capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (col_wrap)
            begin
                col_count_reg <= '0;
                row_count_reg <= row_wrap ? '0 : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_reg <= col_count_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg      <= pixel;
            addr_reg     <= AW'(col_count_reg);
            in_range_reg <= c_in_range;
            orow_reg     <= orow;
            ocol_reg     <= ocol;
            fend_reg     <= col_wrap && row_wrap;
            interior_reg <= interior;
        end
    end

    // line store: read on accept, written back in the following cycle
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_word_reg <= line_mem[AW'(col_count_reg)];
        end
        if (cmd.win && in_range_reg)
        begin
            line_mem[addr_reg] <= {pix_reg, rd_word_reg[2*PIX_W-1:PIX_W]};
        end
    end

    assign above1 = in_range_reg ? rd_word_reg[2*PIX_W-1:PIX_W] : '0;
    assign above2 = in_range_reg ? rd_word_reg[PIX_W-1:0] : '0;

    // window shift
    always_ff @(posedge clk)
    begin
        if (cmd.win)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k*3+0] <= win_reg[k*3+1];
                win_reg[k*3+1] <= win_reg[k*3+2];
            end
            win_reg[2] <= above2;
            win_reg[5] <= above1;
            win_reg[8] <= pix_reg;
        end
    end

    // sobel sums split into positive and negative halves
    assign gx_p = {2'b00, win_reg[2]} + {1'b0, win_reg[5], 1'b0} + {2'b00, win_reg[8]};
    assign gx_n = {2'b00, win_reg[0]} + {1'b0, win_reg[3], 1'b0} + {2'b00, win_reg[6]};
    assign gy_p = {2'b00, win_reg[6]} + {1'b0, win_reg[7], 1'b0} + {2'b00, win_reg[8]};
    assign gy_n = {2'b00, win_reg[0]} + {1'b0, win_reg[1], 1'b0} + {2'b00, win_reg[2]};

    assign s_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // one restoring square root step
    assign rem_sh  = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign root_sh = {root_reg[PIX_W-2:0], 1'b0};
    assign trial   = {{(REM_W+2-PIX_W-1){1'b0}}, root_sh, 1'b1};

    // gradient, squares, sum and root iterations
    always_ff @(posedge clk)
    begin
        if (cmd.grad)
        begin
            gx_abs_reg <= (gx_p >= gx_n) ? gx_p - gx_n : gx_n - gx_p;
            gy_abs_reg <= (gy_p >= gy_n) ? gy_p - gy_n : gy_n - gy_p;
        end
        if (cmd.sq)
        begin
            sqx_reg <= gx_abs_reg * gx_abs_reg;
            sqy_reg <= gy_abs_reg * gy_abs_reg;
        end
        if (cmd.sum)
        begin
            sat_reg      <= |s_sum[S_W-1:RAD_W];
            rad_reg      <= s_sum[RAD_W-1:0];
            rem_reg      <= '0;
            root_reg     <= '0;
            step_cnt_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg      <= {rad_reg[RAD_W-3:0], 2'b00};
            step_cnt_reg <= step_cnt_reg + ROOT_CNT_W'(1);
            if (trial <= rem_sh)
            begin
                rem_reg  <= REM_W'(rem_sh - trial);
                root_reg <= root_sh | PIX_W'(1);
            end
            else
            begin
                rem_reg  <= REM_W'(rem_sh);
                root_reg <= root_sh;
            end
        end
    end

    assign status.root_last   = (step_cnt_reg == ROOT_CNT_W'(ROOT_STEPS - 1));
    assign status.out_blocked = out_valid_reg && out_stall;

    // clamp and border select
    assign edge_sel = !interior_reg ? '0 : (sat_reg ? EDGE_MAX : root_reg);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            edge_value_reg <= edge_sel;
            out_row_reg    <= orow_reg;
            out_col_reg    <= ocol_reg;
            frame_end_reg  <= fend_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign edge_value = edge_value_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_end  = frame_end_reg;

    `SEM_ASSERT_NEXT(a_border_zero, cmd.out_load && !interior_reg, edge_value_reg == '0)
    `SEM_ASSERT_NEXT(a_saturate, cmd.out_load && interior_reg && sat_reg, edge_value_reg == EDGE_MAX)
    `SEM_ASSERT_SAME(a_root_rem_bound, cmd.root_step && interior_reg, rem_reg <= {root_reg, 1'b0})

endmodule

// ===== rtl/core/sobel_edge_magnitude_top.sv =====
// sobel 3x3 edge magnitude: top level with apb registers, controller and datapath
// Usage:
//   Pixels of a frame arrive in raster order on pixel / in_valid; the block
//   raises in_stall while it works on a transaction. Each accepted pixel gives
//   exactly one result on edge_value / out_row / out_col / frame_end with
//   out_valid, held until a cycle with out_stall low takes it.
//   Input (r,c) gives output pixel (r-1,c-1); row 0 and column 0 inputs give
//   the last row and last column. A border three pixels wide reads zero.
//   Per pixel the line store read and write, gradient, squares, sum, an
//   8-step restoring square root (one result bit a step) and the output
//   load run in sequence; the load waits while the receiver stalls a result.
//   A finished result sits in the output register, so the next pixel is
//   taken while the receiver stalls; only a second result waits for it.
//   image_width (offset 0) and image_height (offset 4) are written over apb
//   between frames; pready is always high. Reset clears the position
//   counters and control and sets both sizes to 256; line store contents are
//   undefined until the first rows of a frame are written.
module sobel_edge_magnitude_top #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sem_pkg::PIX_W-1:0]       pixel,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sem_pkg::PIX_W-1:0]       edge_value,
    output logic [sem_pkg::ROW_W-1:0]       out_row,
    output logic [sem_pkg::COL_W-1:0]       out_col,
    output logic                            frame_end,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sem_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sem_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sem_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import sem_pkg::*;

    sem_cmd_t            cmd;
    sem_status_t         status;
    logic [WIDTH_W-1:0]  image_width;
    logic [HEIGHT_W-1:0] image_height;

    // configuration registers
    sem_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .image_width  (image_width),
        .image_height (image_height)
    );

    // sequencing
    sem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and storage
    sem_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .pixel        (pixel),
        .image_width  (image_width),
        .image_height (image_height),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .edge_value   (edge_value),
        .out_row      (out_row),
        .out_col      (out_col),
        .frame_end    (frame_end)
    );

endmodule
